FILE: sv/mmt_pkg.sv
// Shared types, constants and helpers for the matrix multiply transpose unit.
`timescale 1ns / 1ps
package mmt_pkg;

  localparam int MAX_DIM     = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DATA_WIDTH  = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 5;
  localparam int IDX_W       = 4;
  localparam int ELEM_IDX_W  = 8;
  localparam int VAL_W       = 16;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int ACC_W       = 40;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_ROW    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_ROW,
    CMD_ERROR
  } cmd_kind_t;

  typedef enum logic [2:0] {
    REG_ROWS_M  = 3'd0,
    REG_INNER_K = 3'd1,
    REG_COLS_N  = 3'd2,
    REG_A_TRANS = 3'd3,
    REG_B_TRANS = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_WAIT,
    BK_EMIT
  } back_state_t;

  // Saturated dimensions and transpose flags
  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] kd;
    logic [DIM_W-1:0] n;
    logic             a_t;
    logic             b_t;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [ELEM_IDX_W-1:0]  idx;
    logic [VAL_W-1:0]       value;
    logic [IDX_W-1:0]       row;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

FILE: sv/mmt_front.sv
// Front end: configuration registers and request classification.
`timescale 1ns / 1ps
module mmt_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mmt_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [mmt_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [mmt_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mmt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [1:0]                       in_tuser,
  output logic                             push_valid,
  output mmt_pkg::cmd_t                    push_cmd,
  input  logic                             queue_full,
  output mmt_pkg::cfg_t                    cfg
);
  import mmt_pkg::*;

  logic [DIM_W-1:0]   rows_m_r, inner_k_r, cols_n_r;
  logic               a_trans_r, b_trans_r;
  logic               cfg_wr;
  reg_idx_t           reg_sel;
  func_t              func;
  logic [ELEM_IDX_W-1:0] idx;
  logic [2*DIM_W-1:0] size_a, size_b;
  logic [DIM_W-1:0]   n_cap;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= DIM_W'(MAX_DIM);
      inner_k_r <= DIM_W'(MAX_DIM);
      cols_n_r  <= DIM_W'(MAX_DIM);
      a_trans_r <= 1'b0;
      b_trans_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ROWS_M:  rows_m_r  <= cfg_pwdata[DIM_W-1:0];
        REG_INNER_K: inner_k_r <= cfg_pwdata[DIM_W-1:0];
        REG_COLS_N:  cols_n_r  <= cfg_pwdata[DIM_W-1:0];
        REG_A_TRANS: a_trans_r <= cfg_pwdata[0];
        REG_B_TRANS: b_trans_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROWS_M:  cfg_prdata = CFG_DW'(rows_m_r);
      REG_INNER_K: cfg_prdata = CFG_DW'(inner_k_r);
      REG_COLS_N:  cfg_prdata = CFG_DW'(cols_n_r);
      REG_A_TRANS: cfg_prdata = CFG_DW'(a_trans_r);
      REG_B_TRANS: cfg_prdata = CFG_DW'(b_trans_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign n_cap   = clamp_dim(cols_n_r, DIM_W'(MAX_DIM));
  assign cfg.m   = clamp_dim(rows_m_r, DIM_W'(MAX_DIM));
  assign cfg.kd  = clamp_dim(inner_k_r, DIM_W'(MAX_DIM));
  assign cfg.n   = (n_cap > DIM_W'(MAX_RESULTS)) ? DIM_W'(MAX_RESULTS) : n_cap;
  assign cfg.a_t = a_trans_r;
  assign cfg.b_t = b_trans_r;

  assign size_a = (2*DIM_W)'(cfg.m) * (2*DIM_W)'(cfg.kd);
  assign size_b = (2*DIM_W)'(cfg.kd) * (2*DIM_W)'(cfg.n);

  assign func       = func_t'(in_tuser);
  assign idx        = in_tdata[ELEM_IDX_W-1:0];
  assign in_tready  = !queue_full;
  assign push_valid = in_tvalid && !queue_full;

  always_comb begin
    push_cmd.idx   = idx;
    push_cmd.value = in_tdata[ELEM_IDX_W+VAL_W-1:ELEM_IDX_W];
    push_cmd.row   = in_tdata[ELEM_IDX_W+VAL_W+IDX_W-1:ELEM_IDX_W+VAL_W];
    unique case (func)
      FUNC_LOAD_A: push_cmd.kind = ((2*DIM_W)'(idx) < size_a) ? CMD_LOAD_A : CMD_ERROR;
      FUNC_LOAD_B: push_cmd.kind = ((2*DIM_W)'(idx) < size_b) ? CMD_LOAD_B : CMD_ERROR;
      FUNC_ROW:    push_cmd.kind = (DIM_W'(push_cmd.row) < cfg.m) ? CMD_ROW : CMD_ERROR;
      default:     push_cmd.kind = CMD_ERROR;
    endcase
  end

endmodule

FILE: sv/mmt_queue.sv
// Small request queue between the front end and the compute back end.
`timescale 1ns / 1ps
module mmt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  mmt_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output mmt_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import mmt_pkg::*;

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_valid) q_mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push_valid && !pop)      count_r <= count_r + (QPTR_W+1)'(1);
      else if (!push_valid && pop) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

endmodule

FILE: sv/mmt_back.sv
// Back end: element stores, row sequencer, multiply-accumulate and result register.
`timescale 1ns / 1ps
module mmt_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mmt_pkg::cfg_t                   cfg,
  input  mmt_pkg::cmd_t                   pop_cmd,
  input  logic                            empty,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);
  import mmt_pkg::*;

  logic [DATA_WIDTH-1:0] a_mem [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] b_mem [STORE_DEPTH];

  back_state_t state_r, state_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;
  logic             issue, acc_clr, out_ld, out_ld_err, out_free;
  logic             k_last, col_last, wr_a, wr_b;
  logic [IDX_W+DIM_W:0] ai_full, bi_full;
  logic [ADDR_W-1:0]    ai, bi;

  logic signed [DATA_WIDTH-1:0] rd_a_r, rd_b_r;
  logic                         rd_v_r, rd_last_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic                         prod_v_r, prod_last_r;
  logic [ACC_W-1:0]             acc_r;
  logic                         done_r;

  logic             out_valid_r, out_last_r, out_err_r;
  logic [ACC_W-1:0] out_value_r;
  logic [IDX_W-1:0] out_col_r;

  assign out_free = !out_valid_r || out_tready;
  assign k_last   = (DIM_W'(k_r) == cfg.kd - DIM_W'(1));
  assign col_last = (DIM_W'(col_r) == cfg.n - DIM_W'(1));
  assign wr_a     = pop && (pop_cmd.kind == CMD_LOAD_A);
  assign wr_b     = pop && (pop_cmd.kind == CMD_LOAD_B);

  always_comb begin
    ai_full = cfg.a_t ? ((IDX_W+DIM_W+1)'(k_r) * (IDX_W+DIM_W+1)'(cfg.m)
                         + (IDX_W+DIM_W+1)'(row_r))
                      : ((IDX_W+DIM_W+1)'(row_r) * (IDX_W+DIM_W+1)'(cfg.kd)
                         + (IDX_W+DIM_W+1)'(k_r));
    bi_full = cfg.b_t ? ((IDX_W+DIM_W+1)'(col_r) * (IDX_W+DIM_W+1)'(cfg.kd)
                         + (IDX_W+DIM_W+1)'(k_r))
                      : ((IDX_W+DIM_W+1)'(k_r) * (IDX_W+DIM_W+1)'(cfg.n)
                         + (IDX_W+DIM_W+1)'(col_r));
  end
  assign ai = ai_full[ADDR_W-1:0];
  assign bi = bi_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_a) a_mem[ADDR_W'(pop_cmd.idx)] <= DATA_WIDTH'(pop_cmd.value);
    rd_a_r <= a_mem[ai];
  end

  always_ff @(posedge clk) begin
    if (wr_b) b_mem[ADDR_W'(pop_cmd.idx)] <= DATA_WIDTH'(pop_cmd.value);
    rd_b_r <= b_mem[bi];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    k_nxt      = k_r;
    pop        = 1'b0;
    issue      = 1'b0;
    acc_clr    = 1'b0;
    out_ld     = 1'b0;
    out_ld_err = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          unique case (pop_cmd.kind)
            CMD_LOAD_A, CMD_LOAD_B: pop = 1'b1;
            CMD_ERROR: begin
              if (out_free) begin
                pop        = 1'b1;
                out_ld_err = 1'b1;
              end
            end
            CMD_ROW: begin
              pop       = 1'b1;
              row_nxt   = pop_cmd.row;
              col_nxt   = '0;
              k_nxt     = '0;
              acc_clr   = 1'b1;
              state_nxt = BK_RUN;
            end
            default: ;
          endcase
        end
      end
      BK_RUN: begin
        issue = 1'b1;
        if (k_last) state_nxt = BK_WAIT;
        else k_nxt = k_r + IDX_W'(1);
      end
      BK_WAIT: begin
        if (done_r) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (col_last) begin
            state_nxt = BK_IDLE;
          end else begin
            col_nxt   = col_r + IDX_W'(1);
            k_nxt     = '0;
            acc_clr   = 1'b1;
            state_nxt = BK_RUN;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      if (acc_clr) done_r <= 1'b0;
      else if (prod_v_r && prod_last_r) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r   <= k_last;
    prod_r      <= rd_a_r * rd_b_r;
    prod_last_r <= rd_last_r;
    if (acc_clr) acc_r <= '0;
    else if (prod_v_r) acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_ld || out_ld_err) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_value_r <= acc_r;
      out_col_r   <= col_r;
      out_last_r  <= col_last;
      out_err_r   <= 1'b0;
    end else if (out_ld_err) begin
      out_value_r <= '0;
      out_col_r   <= '0;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-ACC_W-IDX_W){1'b0}}, out_col_r, out_value_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

FILE: sv/matrix_multiply_transpose_unit.sv
// Top level of the matrix multiply transpose unit.
`timescale 1ns / 1ps
// Computes rows of C = op(A) * op(B) on signed Q8.8 elements, Q24.16 sums in 40 bits.
// Input stream: tuser selects load A, load B or compute row; tdata carries
// the element index, element value and row number. Loads store one element
// and give no result unless the index is out of range.
// Output stream: one result per column of a requested row, tlast on the last column of
// a row; tuser flags an error result (bad index, bad row or unused code).
// Configuration over the APB port sets M, K, N and the transpose flags;
// write it only while the unit is idle.
// The back end takes loads and rows only while idle. A row is computed by the
// single shared multiply-accumulate unit, which walks K products per column
// and then drains its read, multiply and accumulate registers.
// A 4-entry queue separates request intake from the back end, so input
// requests keep flowing while a row is being computed or a result waits.
// Reset clears the queue, sequencer and output register and restores the
// default 16 x 16 x 16 untransposed setup; stored elements are not cleared.
// When the receiver stalls, the result holds in the output register and the
// back end waits; the queue then fills and in_tready drops.
module matrix_multiply_transpose_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mmt_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [mmt_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [mmt_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] elem_index, [23:8] elem_value, [27:24] row_index, [31:28] zero
  input  logic [mmt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] func
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [39:0] out_value, [43:40] out_col, [47:44] zero
  output logic [mmt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  // [0] out_error
  output logic                             out_tuser
);
  import mmt_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, pop_cmd;
  logic push_valid, queue_full, queue_empty, pop;

  mmt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .queue_full (queue_full),
    .cfg        (cfg)
  );

  mmt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .empty     (queue_empty)
  );

  mmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_cmd   (pop_cmd),
    .empty     (queue_empty),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

FILE: sv/mmt_checker.sv
// Port-level checks for the matrix multiply transpose unit, bound to the top level.
`timescale 1ns / 1ps
module mmt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_pready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);
  import mmt_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled result changed");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("error result not zero with last set");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:ACC_W+IDX_W] == '0))
    else $error("result padding bits not zero");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind matrix_multiply_transpose_unit mmt_checker u_mmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_pready(cfg_pready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);

FILE: tb/mmt_dot_checker.sv
// Predicts and checks the result stream of the matrix multiply transpose unit.
`timescale 1ns / 1ps
module mmt_dot_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mmt_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [mmt_pkg::CFG_DW-1:0]      cfg_pwdata,
  input  logic                            cfg_pready,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [7:0] elem_index, [23:8] elem_value, [27:24] row_index, [31:28] zero
  input  logic [mmt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [39:0] out_value, [43:40] out_col, [47:44] zero
  input  logic [mmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  // [0] out_error
  input  logic                            out_tuser,
  output int                              mismatches,
  output int                              dots_owed
);
  import mmt_pkg::*;

  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic [IDX_W-1:0] col;
    logic             last;
    logic             err;
  } dot_t;

  dot_t                  owed[$];
  logic [DATA_WIDTH-1:0] a_mem [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] b_mem [STORE_DEPTH];
  logic [DIM_W-1:0]      rows_m, inner_k, cols_n;
  logic                  a_t, b_t;

  function automatic int fit_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic owe_error();
    dot_t e;
    e = '0;
    e.last = 1'b1;
    e.err = 1'b1;
    owed.push_back(e);
  endtask

  task automatic predict_request(input logic [1:0] fcode, input logic [ELEM_IDX_W-1:0] idx,
                                 input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] row);
    int     m, kd, n, size, ai, bi;
    longint acc;
    dot_t   d;
    m = fit_dim(rows_m);
    kd = fit_dim(inner_k);
    n = fit_dim(cols_n);
    if (n > MAX_RESULTS) n = MAX_RESULTS;
    case (fcode)
      FUNC_LOAD_A, FUNC_LOAD_B: begin
        size = (fcode == FUNC_LOAD_A) ? m * kd : kd * n;
        if (int'(idx) >= size) owe_error();
        else if (fcode == FUNC_LOAD_A) a_mem[idx] = val;
        else b_mem[idx] = val;
      end
      FUNC_ROW: begin
        if (int'(row) >= m) begin
          owe_error();
        end else begin
          for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < kd; k++) begin
              ai = a_t ? k * m + int'(row) : int'(row) * kd + k;
              bi = b_t ? j * kd + k : k * n + j;
              acc += longint'($signed(a_mem[ai])) * longint'($signed(b_mem[bi]));
            end
            d.value = acc[ACC_W-1:0];
            d.col = IDX_W'(j);
            d.last = (j == n - 1);
            d.err = 1'b0;
            owed.push_back(d);
          end
        end
      end
      default: owe_error();
    endcase
  endtask

  task automatic check_result();
    dot_t got, want;
    got.value = out_tdata[ACC_W-1:0];
    got.col = out_tdata[ACC_W+IDX_W-1:ACC_W];
    got.last = out_tlast;
    got.err = out_tuser;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: value %h col %0d last %b err %b",
                 got.value, got.col, got.last, got.err);
    end else begin
      want = owed.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: exp value %h col %0d last %b err %b, ",
                    "got value %h col %0d last %b err %b"},
                   want.value, want.col, want.last, want.err,
                   got.value, got.col, got.last, got.err);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_m = DIM_W'(MAX_DIM);
      inner_k = DIM_W'(MAX_DIM);
      cols_n = DIM_W'(MAX_DIM);
      a_t = 1'b0;
      b_t = 1'b0;
      owed.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_ROWS_M:  rows_m = cfg_pwdata[DIM_W-1:0];
          REG_INNER_K: inner_k = cfg_pwdata[DIM_W-1:0];
          REG_COLS_N:  cols_n = cfg_pwdata[DIM_W-1:0];
          REG_A_TRANS: a_t = cfg_pwdata[0];
          REG_B_TRANS: b_t = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready)
        predict_request(in_tuser, in_tdata[ELEM_IDX_W-1:0],
                        in_tdata[ELEM_IDX_W+VAL_W-1:ELEM_IDX_W],
                        in_tdata[ELEM_IDX_W+VAL_W+IDX_W-1:ELEM_IDX_W+VAL_W]);
    end
    dots_owed <= owed.size();
  end

endmodule

FILE: tb/matrix_multiply_transpose_unit_tb.sv
// Stimulus, clocking and verdict for the matrix multiply transpose unit.
`timescale 1ns / 1ps
module matrix_multiply_transpose_unit_tb;
  import mmt_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr = '0;
  logic [CFG_DW-1:0]      cfg_pwdata = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  int                     mismatches;
  int                     dots_owed;
  int                     items_sent = 0;
  int                     cur_m = MAX_DIM, cur_k = MAX_DIM, cur_n = MAX_DIM;
  bit                     steady = 1'b0;

  matrix_multiply_transpose_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  mmt_dot_checker dot_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .mismatches(mismatches), .dots_owed(dots_owed)
  );

  always #2 clk = ~clk;

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: ready stretches broken by stalls, now and then a long one
  initial begin
    int mode, run, stall;
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        run = $urandom_range(50, 200);
        stall = 0;
      end else begin
        run = $urandom_range(1, 6);
        stall = (mode == 9) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic int fit_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(17, 31));
    if (r == 2) return DIM_W'(MAX_DIM);
    return DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    return VAL_W'($urandom());
  endfunction

  task automatic send_item(input func_t f, input logic [ELEM_IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] row);
    int gap, r;
    r = $urandom_range(0, 19);
    if (steady || r < 10) gap = 0;
    else if (r < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {4'b0, row, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // hold off until every owed result is out, then let queued loads retire
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (dots_owed != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [DIM_W-1:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= ($urandom() & 32'hffff_ffe0) | CFG_DW'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [DIM_W-1:0] m, input logic [DIM_W-1:0] k,
                           input logic [DIM_W-1:0] n, input bit at, input bit bt);
    wait_idle();
    write_reg(REG_ROWS_M, m);
    write_reg(REG_INNER_K, k);
    write_reg(REG_COLS_N, n);
    write_reg(REG_A_TRANS, DIM_W'(at));
    write_reg(REG_B_TRANS, DIM_W'(bt));
    cur_m = fit_dim(m);
    cur_k = fit_dim(k);
    cur_n = fit_dim(n);
    steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0 && cur_m * cur_k < STORE_DEPTH)
      send_item(FUNC_LOAD_A, ELEM_IDX_W'($urandom_range(cur_m * cur_k, STORE_DEPTH - 1)),
                VAL_W'($urandom()), IDX_W'($urandom()));
    else if (r == 1 && cur_k * cur_n < STORE_DEPTH)
      send_item(FUNC_LOAD_B, ELEM_IDX_W'($urandom_range(cur_k * cur_n, STORE_DEPTH - 1)),
                VAL_W'($urandom()), IDX_W'($urandom()));
    else if (r == 2 && cur_m < MAX_DIM)
      send_item(FUNC_ROW, ELEM_IDX_W'($urandom()), VAL_W'($urandom()),
                IDX_W'($urandom_range(cur_m, MAX_DIM - 1)));
    else
      send_item(FUNC_NONE, ELEM_IDX_W'($urandom()), VAL_W'($urandom()),
                IDX_W'($urandom()));
  endtask

  task automatic load_operands();
    for (int i = 0; i < cur_m * cur_k; i++) begin
      if ($urandom_range(0, 15) == 0) send_noise();
      send_item(FUNC_LOAD_A, ELEM_IDX_W'(i), pick_value(), IDX_W'($urandom()));
    end
    for (int i = 0; i < cur_k * cur_n; i++) begin
      if ($urandom_range(0, 15) == 0) send_noise();
      send_item(FUNC_LOAD_B, ELEM_IDX_W'(i), pick_value(), IDX_W'($urandom()));
    end
  endtask

  task automatic run_ops(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12)
        send_item(FUNC_ROW, ELEM_IDX_W'($urandom()), VAL_W'($urandom()),
                  IDX_W'($urandom_range(0, cur_m - 1)));
      else if (r < 14)
        send_item(FUNC_ROW, ELEM_IDX_W'($urandom()), VAL_W'($urandom()),
                  IDX_W'($urandom_range(0, MAX_DIM - 1)));
      else if (r < 16)
        send_item(FUNC_LOAD_A, ELEM_IDX_W'($urandom_range(0, cur_m * cur_k - 1)),
                  pick_value(), IDX_W'($urandom()));
      else if (r < 18)
        send_item(FUNC_LOAD_B, ELEM_IDX_W'($urandom_range(0, cur_k * cur_n - 1)),
                  pick_value(), IDX_W'($urandom()));
      else
        send_noise();
    end
  endtask

  initial begin
    int phase;
    logic [DIM_W-1:0] m, k, n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // default 16x16x16 shape: top corners of both stores, unused code
    send_item(FUNC_LOAD_A, 8'd255, 16'h7fff, 4'd15);
    send_item(FUNC_LOAD_B, 8'd255, 16'h8000, 4'd0);
    send_item(FUNC_NONE, 8'hff, 16'hffff, 4'hf);

    // 2x2x2 with extreme operands, then every error path
    set_shape(5'd2, 5'd2, 5'd2, 1'b0, 1'b0);
    send_item(FUNC_LOAD_A, 8'd0, 16'h7fff, 4'd0);
    send_item(FUNC_LOAD_A, 8'd1, 16'h7fff, 4'd0);
    send_item(FUNC_LOAD_A, 8'd2, 16'h8000, 4'd0);
    send_item(FUNC_LOAD_A, 8'd3, 16'h8000, 4'd0);
    send_item(FUNC_LOAD_B, 8'd0, 16'h7fff, 4'd0);
    send_item(FUNC_LOAD_B, 8'd1, 16'h8000, 4'd0);
    send_item(FUNC_LOAD_B, 8'd2, 16'h7fff, 4'd0);
    send_item(FUNC_LOAD_B, 8'd3, 16'h8000, 4'd0);
    send_item(FUNC_ROW, 8'hff, 16'hffff, 4'd0);
    send_item(FUNC_ROW, 8'h00, 16'h0000, 4'd1);
    send_item(FUNC_ROW, 8'h00, 16'h0000, 4'd2);
    send_item(FUNC_ROW, 8'h00, 16'h0000, 4'd15);
    send_item(FUNC_LOAD_A, 8'd4, 16'h1234, 4'd0);
    send_item(FUNC_LOAD_B, 8'd255, 16'h5678, 4'd0);
    send_item(FUNC_NONE, 8'h00, 16'h0000, 4'd0);

    phase = 0;
    while (items_sent < 315) begin
      case (phase)
        0: set_shape(5'd16, 5'd1, 5'd16, 1'b0, 1'b1);
        1: set_shape(5'd1, 5'd16, 5'd2, 1'b1, 1'b0);
        2: set_shape(5'd0, 5'd31, 5'd1, 1'b1, 1'b1);
        3: set_shape(5'd3, 5'd2, 5'd0, 1'b0, 1'b0);
        default: begin
          do begin
            m = pick_dim();
            k = pick_dim();
            n = pick_dim();
          end while (fit_dim(m) * fit_dim(k) > 64 || fit_dim(k) * fit_dim(n) > 64);
          set_shape(m, k, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      endcase
      load_operands();
      run_ops($urandom_range(6, 16));
      phase++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && dots_owed == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
